>>> design/abps_pkg.sv
// Package for the aligned byte pattern search unit.
// Holds the sizing constants, configuration register indexes and the needle byte selector.
// No dependencies.
`default_nettype none

package abps_pkg;

  localparam int PATTERN_MAX   = 32;
  localparam int POSITION_BITS = 32;
  localparam int LEN_W         = 6;
  localparam int ALIGN_W       = 16;
  localparam int WORD_W        = 64;
  localparam int WORDS         = 4;
  localparam int NEEDLE_W      = WORD_W * WORDS;
  localparam int NIDX_W        = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int OFFSET_W      = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD3  = 3'd5;

  typedef logic [7:0]          byte_t;
  typedef logic [NEEDLE_W-1:0] needle_t;

  function automatic byte_t needle_byte(needle_t needle, logic [NIDX_W-1:0] idx);
    logic [NIDX_W+2:0] base;
    base = {idx, 3'b000};
    return needle[base +: 8];
  endfunction

endpackage

`default_nettype wire

>>> design/abps_cell.sv
// One cell of the search window: holds one haystack byte and compares the byte entering it.
// Depends on abps_pkg.
`default_nettype none

module abps_cell
  import abps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  shift_en,
  input  wire byte_t byte_in,
  input  wire byte_t needle,
  input  wire logic  in_use,
  output byte_t      byte_out,
  output logic       hit
);

  byte_t byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = !in_use || (byte_in == needle);

endmodule

`default_nettype wire

>>> design/aligned_byte_pattern_search_unit.sv
// Aligned byte pattern search unit: top level with configuration registers, window and result.
// Depends on abps_pkg and abps_cell.
//
// Usage: haystack bytes enter on the in_ channel, one per beat, with in_text_end marking the
// final byte of a haystack. A beat is taken when in_valid is high and in_stall is low. The
// needle, its length and the alignment are written through the cfg_ channel (index, data); the
// user must write them only while the unit is idle; the unit does not enforce it. cfg_ready is
// always high. Each byte shifts through a chain of 32 cells that compare it against the needle
// in the same cycle, so one byte is taken every cycle while in_stall is low. One result beat
// comes per haystack: on the byte that completes the first aligned match (out_found high,
// out_match_offset the start offset), or on the final byte when nothing matched (out_found
// low, offset zero). A result appears on the out_ channel in the cycle after its byte.
// The result register frees itself in the same cycle it is taken, so input is only held off
// while a result waits and out_stall is high; in_stall then follows out_stall.
// Reset returns length and alignment to 1, clears the needle and starts a fresh haystack.
`default_nettype none

module aligned_byte_pattern_search_unit
  import abps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  in_text_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_found,
  output logic [OFFSET_W-1:0]        out_match_offset,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]         len_r;
  logic [ALIGN_W-1:0]       align_r;
  needle_t                  needle_r;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [ALIGN_W-1:0]       phase_r, phase_nxt;
  logic                     reported_r, reported_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [OFFSET_W-1:0]      out_offset_r, out_offset_nxt;

  logic                     in_fire;
  logic                     shift_en;
  byte_t                    chain [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]   hits;
  logic                     all_hit;
  logic [POSITION_BITS:0]   pos_plus1;
  logic                     len_ok;
  logic                     window_ok;
  logic [ALIGN_W-1:0]       align_eff;
  logic [ALIGN_W:0]         phase_inc;
  logic                     matched;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_W'(1);
      align_r  <= ALIGN_W'(1);
      needle_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: len_r   <= cfg_data[LEN_W-1:0];
        CFG_ALIGNMENT:      align_r <= cfg_data[ALIGN_W-1:0];
        CFG_PATTERN_WORD0:  needle_r[0*WORD_W +: WORD_W] <= cfg_data;
        CFG_PATTERN_WORD1:  needle_r[1*WORD_W +: WORD_W] <= cfg_data;
        CFG_PATTERN_WORD2:  needle_r[2*WORD_W +: WORD_W] <= cfg_data;
        CFG_PATTERN_WORD3:  needle_r[3*WORD_W +: WORD_W] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign shift_en = in_fire && !reported_r;

  assign chain[0] = in_text_byte;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [NIDX_W-1:0] nidx;
    assign nidx = NIDX_W'(len_r - LEN_W'(k + 1));
    if (k < PATTERN_MAX - 1) begin : g_mid
      abps_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .byte_in  (chain[k]),
        .needle   (needle_byte(needle_r, nidx)),
        .in_use   (len_r > LEN_W'(k)),
        .byte_out (chain[k+1]),
        .hit      (hits[k])
      );
    end else begin : g_end
      abps_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .byte_in  (chain[k]),
        .needle   (needle_byte(needle_r, nidx)),
        .in_use   (len_r > LEN_W'(k)),
        .byte_out (),
        .hit      (hits[k])
      );
    end
  end

  assign all_hit   = &hits;
  assign pos_plus1 = {1'b0, pos_r} + (POSITION_BITS+1)'(1);
  assign len_ok    = (len_r != '0) && (len_r <= LEN_W'(PATTERN_MAX));
  assign window_ok = len_ok && (pos_r != POS_MAX) &&
                     (pos_plus1 >= (POSITION_BITS+1)'(len_r));
  assign align_eff = (align_r == '0) ? ALIGN_W'(1) : align_r;
  assign phase_inc = {1'b0, phase_r} + (ALIGN_W+1)'(1);
  assign matched   = !reported_r && window_ok && (phase_r == '0) && all_hit;

  always_comb begin
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    reported_nxt   = reported_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    if (in_fire) begin
      if (!reported_r) begin
        if (window_ok) begin
          phase_nxt = (phase_inc >= {1'b0, align_eff}) ? '0 : phase_inc[ALIGN_W-1:0];
        end
        if (matched) begin
          reported_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b1;
          out_offset_nxt = OFFSET_W'(pos_plus1 - (POSITION_BITS+1)'(len_r));
        end
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_plus1[POSITION_BITS-1:0];
        end
      end
      if (in_text_end) begin
        if (!reported_r && !matched) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b0;
          out_offset_nxt = '0;
        end
        pos_nxt      = '0;
        phase_nxt    = '0;
        reported_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_text_end) |=> (!reported_r && pos_r == '0 && phase_r == '0))
    else $error("haystack end did not clear the search state");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_offset_r == '0))
    else $error("not-found result carries a nonzero offset");

  a_match_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && matched && !in_text_end) |=> (reported_r && out_valid_r && out_found_r))
    else $error("match did not raise a found beat");

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && window_ok && !reported_r && !in_text_end) |=>
      (phase_r < $past(align_eff)))
    else $error("start phase escaped the alignment");

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for aligned_byte_pattern_search_unit.
// Haystack bytes are sent as beats under random idling and stalls, and each result beat is
// checked against a predictor of the aligned first-match search. Depends on abps_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abps_pkg::*;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } match_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_text_byte = '0;
  logic                  in_text_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_found;
  logic [OFFSET_W-1:0]   out_match_offset;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  byte_t             window_q [PATTERN_MAX];
  longint unsigned   seen_cnt;
  int unsigned       phase_cnt;
  bit                hit_done;
  logic [LEN_W-1:0]   cur_len;
  logic [ALIGN_W-1:0] cur_align;
  needle_t           cur_needle;

  match_t expected_results[$];
  int     mismatches = 0;
  int     bytes_sent = 0;
  bit     quiet = 1'b0;

  aligned_byte_pattern_search_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_text_end      (in_text_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 23);
  end

  function automatic void clear_search();
    foreach (window_q[i]) window_q[i] = '0;
    seen_cnt  = 0;
    phase_cnt = 0;
    hit_done  = 1'b0;
  endfunction

  function automatic bit search_byte(input byte_t b, input bit e, output match_t r);
    bit          hit;
    bit          cand;
    bit          eq;
    int unsigned len;
    int unsigned al_eff;
    int unsigned nxt;
    hit    = 1'b0;
    r      = '0;
    len    = cur_len;
    al_eff = (cur_align == 0) ? 1 : cur_align;
    if (!hit_done) begin
      for (int i = PATTERN_MAX - 1; i > 0; i--) window_q[i] = window_q[i-1];
      window_q[0] = b;
      if (len >= 1 && len <= PATTERN_MAX && seen_cnt < POS_MAX && seen_cnt + 1 >= len) begin
        cand      = (phase_cnt == 0);
        nxt       = phase_cnt + 1;
        phase_cnt = (nxt >= al_eff) ? 0 : nxt;
        if (cand) begin
          eq = 1'b1;
          for (int j = 0; j < len; j++) begin
            if (window_q[len-1-j] != cur_needle[8*j +: 8]) eq = 1'b0;
          end
          if (eq) begin
            hit_done = 1'b1;
            r.found  = 1'b1;
            r.offset = OFFSET_W'(seen_cnt + 1 - len);
            hit      = 1'b1;
          end
        end
      end
      if (seen_cnt < POS_MAX) seen_cnt++;
    end
    if (e) begin
      if (!hit_done) begin
        r   = '0;
        hit = 1'b1;
      end
      clear_search();
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", 32'h0, {31'h0, out_found});
      end else begin
        want = expected_results.pop_front();
        if (out_found !== want.found)
          report_mismatch("found", {31'h0, want.found}, {31'h0, out_found});
        if (out_match_offset !== want.offset)
          report_mismatch("match offset", want.offset, out_match_offset);
      end
    end
  end

  task automatic send_byte(input byte_t b, input bit e);
    match_t r;
    int     gap;
    gap = (!quiet && $urandom_range(0, 99) < 23) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_text_end  <= e;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (search_byte(b, e, r)) expected_results.push_back(r);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_PATTERN_LENGTH: cur_len = data[LEN_W-1:0];
      CFG_ALIGNMENT:      cur_align = data[ALIGN_W-1:0];
      CFG_PATTERN_WORD0:  cur_needle[0 +: WORD_W] = data;
      CFG_PATTERN_WORD1:  cur_needle[WORD_W +: WORD_W] = data;
      CFG_PATTERN_WORD2:  cur_needle[2*WORD_W +: WORD_W] = data;
      CFG_PATTERN_WORD3:  cur_needle[3*WORD_W +: WORD_W] = data;
      default: ;
    endcase
  endtask

  task automatic configure(input int len, input int align, input needle_t nd);
    write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_ALIGNMENT, CFG_DATA_W'(align));
    write_reg(CFG_PATTERN_WORD0, nd[0 +: WORD_W]);
    write_reg(CFG_PATTERN_WORD1, nd[WORD_W +: WORD_W]);
    write_reg(CFG_PATTERN_WORD2, nd[2*WORD_W +: WORD_W]);
    write_reg(CFG_PATTERN_WORD3, nd[3*WORD_W +: WORD_W]);
    cfg_valid <= 1'b0;
  endtask

  // Reset settings: a one-byte needle of zero.
  task automatic test_reset_needle();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_plain_search();
    configure(3, 1, {{3{64'hFFFF_FFFF_FFFF_FFFF}}, 64'hFFFF_FFFF_FFC3_5AA5});
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    wait_idle();
  endtask

  task automatic test_zero_alignment();
    configure(1, 0, needle_t'(64'h42));
    send_byte(8'h01, 1'b0);
    send_byte(8'h42, 1'b1);
    wait_idle();
  endtask

  task automatic test_invalid_lengths();
    configure(0, 1, '0);
    send_byte(8'h00, 1'b1);
    wait_idle();
    configure(63, 1, '0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  // The alignment changes part way through a haystack; the phase count carries on.
  task automatic test_realign_midstream();
    configure(1, 3, needle_t'(64'h42));
    repeat (4) send_byte(8'h00, 1'b0);
    wait_idle();
    write_reg(CFG_ALIGNMENT, CFG_DATA_W'(2));
    cfg_valid <= 1'b0;
    send_byte(8'h42, 1'b0);
    send_byte(8'h42, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_haystacks();
    byte_t   nb [PATTERN_MAX];
    byte_t   hay[$];
    needle_t nd;
    byte_t   base;
    byte_t   mask;
    int      len;
    int      align;
    int      al_eff;
    int      hay_len;
    int      lo;
    int      s;
    int      sel;
    int      phase_no;
    bit      noise;
    phase_no = 0;
    while (bytes_sent < 1850) begin
      quiet = (phase_no == 2);
      sel = $urandom_range(0, 99);
      if (sel < 55) len = $urandom_range(1, 4);
      else if (sel < 80) len = $urandom_range(5, 12);
      else if (sel < 88) len = PATTERN_MAX;
      else if (sel < 92) len = $urandom_range(13, 31);
      else if (sel < 96) len = 0;
      else len = $urandom_range(33, 63);
      sel = $urandom_range(0, 99);
      if (sel < 50) align = 1;
      else if (sel < 80) align = $urandom_range(2, 4);
      else if (sel < 88) align = $urandom_range(5, 300);
      else if (sel < 92) align = 65535;
      else if (sel < 96) align = 0;
      else align = $urandom_range(301, 65534);
      sel = $urandom_range(0, 99);
      mask = (sel < 50) ? 8'h01 : (sel < 80) ? 8'h03 : 8'hFF;
      base = $urandom_range(0, 255);
      foreach (nb[i]) begin
        nb[i] = base ^ (byte_t'($urandom) & mask);
        nd[8*i +: 8] = nb[i];
      end
      configure(len, align, nd);
      al_eff = (align == 0) ? 1 : align;
      repeat ($urandom_range(4, 10)) begin
        hay.delete();
        if (len >= 1 && len <= PATTERN_MAX) begin
          lo = (len > 2) ? len - 2 : 1;
          hay_len = ($urandom_range(0, 99) < 85) ? $urandom_range(lo, len + 16)
                                                 : $urandom_range(len + 17, len + 60);
        end else begin
          hay_len = $urandom_range(1, 30);
        end
        noise = ($urandom_range(0, 99) < 15);
        repeat (hay_len) begin
          hay.push_back(noise ? byte_t'($urandom) : base ^ (byte_t'($urandom) & mask));
        end
        if (len >= 1 && len <= PATTERN_MAX && hay_len >= len && $urandom_range(0, 99) < 60) begin
          s = al_eff * $urandom_range(0, (hay_len - len) / al_eff);
          for (int j = 0; j < len; j++) hay[s+j] = nb[j];
          if ($urandom_range(0, 99) < 20)
            hay[s + $urandom_range(0, len - 1)] ^= byte_t'(1 << $urandom_range(0, 7));
        end
        foreach (hay[i]) send_byte(hay[i], i == hay_len - 1);
      end
      wait_idle();
      phase_no++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    cur_len    = 1;
    cur_align  = 1;
    cur_needle = '0;
    clear_search();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_needle();
    test_plain_search();
    test_zero_alignment();
    test_invalid_lengths();
    test_realign_midstream();
    test_random_haystacks();
    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
